// File: sv/rdsc_pkg.sv
// ----------------------------------------------------------------------------
// rdsc_pkg: shared types and constants of the RPN digit stack calculator
// Character codes, status codes, field widths and sequencer state encoding.
// ----------------------------------------------------------------------------
package rdsc_pkg;

   localparam int ValueWidth  = 32;
   localparam int StatusWidth = 3;
   localparam int DepthWidth  = 6;
   localparam int CharWidth   = 8;

   // Characters
   localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CharWidth-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CharWidth-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [CharWidth-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CharWidth-1:0] CHAR_STAR  = 8'h2a;
   localparam logic [CharWidth-1:0] CHAR_SLASH = 8'h2f;
   localparam logic [CharWidth-1:0] CHAR_EQUAL = 8'h3d;

   // Result status codes
   localparam logic [StatusWidth-1:0] ST_PUSHED      = 3'd0;
   localparam logic [StatusWidth-1:0] ST_RESULT      = 3'd1;
   localparam logic [StatusWidth-1:0] ST_NOT_ONE     = 3'd2;
   localparam logic [StatusWidth-1:0] ST_OVERFLOW    = 3'd3;
   localparam logic [StatusWidth-1:0] ST_UNDERFLOW   = 3'd4;
   localparam logic [StatusWidth-1:0] ST_DIV_ZERO    = 3'd5;
   localparam logic [StatusWidth-1:0] ST_UNSUPPORTED = 3'd6;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_RD_B  = 11'b000_0000_0010,
      S_RD_A  = 11'b000_0000_0100,
      S_PREP  = 11'b000_0000_1000,
      S_ABS_A = 11'b000_0001_0000,
      S_ABS_B = 11'b000_0010_0000,
      S_DIV   = 11'b000_0100_0000,
      S_MUL   = 11'b000_1000_0000,
      S_NEG   = 11'b001_0000_0000,
      S_PUSH  = 11'b010_0000_0000,
      S_RD_EQ = 11'b100_0000_0000
   } state_type;

endpackage

// File: sv/rpn_digit_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_digit_stack_calculator: RPN calculator over a stack of 32-bit entries
// One character per request; one response per request.
// ----------------------------------------------------------------------------
// Each request carries one character. A digit pushes its value; '+', '-', '*'
// and '/' pop b (top) and a (below), push a op b with 32-bit wrapping, and
// division truncates toward zero. '=' presents the single held entry. Every
// request yields exactly one response {value, status, depth}; error statuses
// carry a zero value and leave the stack as it was, except divide by zero,
// which drops both operands. Requests are taken one at a time: req_tready is
// high only while the sequencer is idle and no response is waiting. The
// 32-step shift-and-add multiply and restoring divide loops both run one
// bit per cycle on the single shared 33-bit adder; the stack memory has
// one registered read port, so b and a are fetched one after the other.
// The stack needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module rpn_digit_stack_calculator #(
   parameter int STACK_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [31:0] value, [34:32] status, [40:35] depth
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int VW = rdsc_pkg::ValueWidth;
   localparam int PadWidth = 48 - VW - rdsc_pkg::StatusWidth - rdsc_pkg::DepthWidth;

   // Stack storage: one write port, one registered read port
   logic [VW-1:0] stack_mem [STACK_DEPTH];
   logic [VW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [VW-1:0] wr_data;
   logic          wr_en;

   rdsc_pkg::state_type state_ff, state_in;
   rdsc_pkg::op_type    op_ff, op_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [VW-1:0]       opa_ff, opa_in;   // a / multiplicand / dividend-quotient
   logic [VW-1:0]       opb_ff, opb_in;   // b / multiplier / divisor
   logic [VW-1:0]       acc_ff, acc_in;   // result / product / remainder
   logic [4:0]          iter_ff, iter_in;
   logic                neg_ff, neg_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                     rsp_value_ff, rsp_value_in;
   logic [rdsc_pkg::StatusWidth-1:0]  rsp_status_ff, rsp_status_in;
   logic [rdsc_pkg::DepthWidth-1:0]   rsp_depth_ff, rsp_depth_in;

   // Shared adder
   logic [VW:0]   add_x, add_y, add_sum;
   logic          add_cin;
   logic [VW-1:0] rem_shift;

   logic [CW-1:0] ptr_m1, ptr_m2;
   logic          req_fire;
   logic [7:0]    ch;

   assign req_tready = (state_ff == rdsc_pkg::S_IDLE) && !rsp_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign ch         = req_tdata;
   assign ptr_m1     = count_ff - CW'(1);
   assign ptr_m2     = count_ff - CW'(2);
   assign rem_shift  = {acc_ff[VW-2:0], opa_ff[VW-1]};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PadWidth{1'b0}}, rsp_depth_ff, rsp_status_ff, rsp_value_ff};

   // Operand selection for the shared adder
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_cin = 1'b0;
      case (state_ff)
         rdsc_pkg::S_PREP: begin
            add_x   = {1'b0, opa_ff};
            add_y   = (op_ff == rdsc_pkg::OP_SUB) ? {1'b0, ~opb_ff} : {1'b0, opb_ff};
            add_cin = (op_ff == rdsc_pkg::OP_SUB);
         end
         rdsc_pkg::S_MUL: begin
            add_x = {1'b0, acc_ff};
            add_y = opb_ff[0] ? {1'b0, opa_ff} : '0;
         end
         rdsc_pkg::S_ABS_A, rdsc_pkg::S_NEG: begin
            add_y   = {1'b0, ~opa_ff};
            add_cin = 1'b1;
         end
         rdsc_pkg::S_ABS_B: begin
            add_y   = {1'b0, ~opb_ff};
            add_cin = 1'b1;
         end
         rdsc_pkg::S_DIV: begin
            // trial subtract; carry out means no borrow
            add_x   = {1'b0, rem_shift};
            add_y   = {1'b0, ~opb_ff};
            add_cin = 1'b1;
         end
         default: begin
            add_x = '0;
         end
      endcase
   end

   assign add_sum = add_x + add_y + (VW+1)'(add_cin);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      acc_in        = acc_ff;
      iter_in       = iter_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;
      rd_addr       = ptr_m1[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = acc_ff;

      case (state_ff)
         rdsc_pkg::S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               if (ch >= rdsc_pkg::CHAR_ZERO && ch <= rdsc_pkg::CHAR_NINE) begin
                  if (count_ff == CW'(STACK_DEPTH)) begin
                     rsp_status_in = rdsc_pkg::ST_OVERFLOW;
                  end else begin
                     wr_en         = 1'b1;
                     wr_data       = VW'(ch - rdsc_pkg::CHAR_ZERO);
                     count_in      = count_ff + CW'(1);
                     rsp_value_in  = wr_data;
                     rsp_status_in = rdsc_pkg::ST_PUSHED;
                  end
               end else if (ch == rdsc_pkg::CHAR_PLUS || ch == rdsc_pkg::CHAR_MINUS ||
                            ch == rdsc_pkg::CHAR_STAR || ch == rdsc_pkg::CHAR_SLASH) begin
                  if (count_ff < CW'(2)) begin
                     rsp_status_in = rdsc_pkg::ST_UNDERFLOW;
                  end else begin
                     // hold the response until the operation finishes
                     rsp_valid_in = 1'b0;
                     state_in     = rdsc_pkg::S_RD_B;
                     if (ch == rdsc_pkg::CHAR_PLUS) begin
                        op_in = rdsc_pkg::OP_ADD;
                     end else if (ch == rdsc_pkg::CHAR_MINUS) begin
                        op_in = rdsc_pkg::OP_SUB;
                     end else if (ch == rdsc_pkg::CHAR_STAR) begin
                        op_in = rdsc_pkg::OP_MUL;
                     end else begin
                        op_in = rdsc_pkg::OP_DIV;
                     end
                  end
               end else if (ch == rdsc_pkg::CHAR_EQUAL) begin
                  rd_addr = '0;
                  if (count_ff != CW'(1)) begin
                     rsp_status_in = rdsc_pkg::ST_NOT_ONE;
                  end else begin
                     rsp_valid_in = 1'b0;
                     state_in     = rdsc_pkg::S_RD_EQ;
                  end
               end else begin
                  rsp_status_in = rdsc_pkg::ST_UNSUPPORTED;
               end
               rsp_depth_in = rdsc_pkg::DepthWidth'(count_in);
            end
         end
         rdsc_pkg::S_RD_B: begin
            opb_in   = rd_data_ff;
            rd_addr  = ptr_m2[AW-1:0];
            state_in = rdsc_pkg::S_RD_A;
         end
         rdsc_pkg::S_RD_A: begin
            opa_in   = rd_data_ff;
            state_in = rdsc_pkg::S_PREP;
         end
         rdsc_pkg::S_PREP: begin
            iter_in = '0;
            case (op_ff)
               rdsc_pkg::OP_ADD, rdsc_pkg::OP_SUB: begin
                  acc_in   = add_sum[VW-1:0];
                  state_in = rdsc_pkg::S_PUSH;
               end
               rdsc_pkg::OP_MUL: begin
                  acc_in   = '0;
                  state_in = rdsc_pkg::S_MUL;
               end
               default: begin
                  if (opb_ff == '0) begin
                     // drop both operands, push nothing
                     count_in      = ptr_m2;
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = rdsc_pkg::ST_DIV_ZERO;
                     rsp_depth_in  = rdsc_pkg::DepthWidth'(ptr_m2);
                     state_in      = rdsc_pkg::S_IDLE;
                  end else begin
                     neg_in   = opa_ff[VW-1] ^ opb_ff[VW-1];
                     acc_in   = '0;
                     state_in = rdsc_pkg::S_ABS_A;
                  end
               end
            endcase
         end
         rdsc_pkg::S_ABS_A: begin
            if (opa_ff[VW-1]) begin
               opa_in = add_sum[VW-1:0];
            end
            state_in = rdsc_pkg::S_ABS_B;
         end
         rdsc_pkg::S_ABS_B: begin
            if (opb_ff[VW-1]) begin
               opb_in = add_sum[VW-1:0];
            end
            state_in = rdsc_pkg::S_DIV;
         end
         rdsc_pkg::S_DIV: begin
            // restoring step: shift remainder/quotient pair, subtract if it fits
            acc_in  = add_sum[VW] ? add_sum[VW-1:0] : rem_shift;
            opa_in  = {opa_ff[VW-2:0], add_sum[VW]};
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'd31) begin
               state_in = rdsc_pkg::S_NEG;
            end
         end
         rdsc_pkg::S_MUL: begin
            // shift-and-add, multiplier LSB first
            acc_in  = add_sum[VW-1:0];
            opa_in  = {opa_ff[VW-2:0], 1'b0};
            opb_in  = {1'b0, opb_ff[VW-1:1]};
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'd31) begin
               state_in = rdsc_pkg::S_PUSH;
            end
         end
         rdsc_pkg::S_NEG: begin
            acc_in   = neg_ff ? add_sum[VW-1:0] : opa_ff;
            state_in = rdsc_pkg::S_PUSH;
         end
         rdsc_pkg::S_PUSH: begin
            wr_en         = 1'b1;
            wr_addr       = ptr_m2[AW-1:0];
            wr_data       = acc_ff;
            count_in      = ptr_m1;
            rsp_valid_in  = 1'b1;
            rsp_value_in  = acc_ff;
            rsp_status_in = rdsc_pkg::ST_PUSHED;
            rsp_depth_in  = rdsc_pkg::DepthWidth'(ptr_m1);
            state_in      = rdsc_pkg::S_IDLE;
         end
         rdsc_pkg::S_RD_EQ: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = rd_data_ff;
            rsp_status_in = rdsc_pkg::ST_RESULT;
            rsp_depth_in  = rdsc_pkg::DepthWidth'(count_ff);
            state_in      = rdsc_pkg::S_IDLE;
         end
         default: begin
            state_in = rdsc_pkg::S_IDLE;
         end
      endcase
   end

   // Stack memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rdsc_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      opa_ff        <= opa_in;
      opb_ff        <= opb_in;
      acc_ff        <= acc_in;
      iter_ff       <= iter_in;
      neg_ff        <= neg_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count above depth");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != rdsc_pkg::ST_PUSHED &&
      rsp_status_ff != rdsc_pkg::ST_RESULT |-> rsp_value_ff == '0)
      else $error("error response with nonzero value");

   a_count_source: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> $past(req_fire) || $past(state_ff == rdsc_pkg::S_PUSH) ||
      $past(state_ff == rdsc_pkg::S_PREP))
      else $error("stack count moved outside an update step");

   a_div_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == rdsc_pkg::S_DIV && iter_ff == 5'd31 |=> state_ff == rdsc_pkg::S_NEG)
      else $error("divide loop did not end after 32 steps");

endmodule

// File: tb/sv/rpn_digit_stack_calculator_test.sv
// ----------------------------------------------------------------------------
// rpn_digit_stack_calculator_test: self-checking bench for the RPN calculator
// Streams characters into the calculator and keeps its own copy of the
// stack. Every response is checked field by field against that copy. The
// sender runs in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module rpn_digit_stack_calculator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StackDepth    = 32;
   localparam int RandomItems   = 1600;
   localparam int IdleLimit     = 5000;  // cycles with no handshake on either side
   localparam int SettleCycles  = 60;    // longer than the slowest operation ('/')
   localparam int HoldOffCycles = 300;

   // One calculator state: the stack and its fill level.
   typedef struct {
      logic [StackDepth-1:0][rdsc_pkg::ValueWidth-1:0] entries;
      int unsigned                                     count;
   } calc_state_type;

   // Laid out as rsp_tdata[40:0].
   typedef struct packed {
      logic [rdsc_pkg::DepthWidth-1:0]  depth;
      logic [rdsc_pkg::StatusWidth-1:0] status;
      logic [rdsc_pkg::ValueWidth-1:0]  value;
   } calc_result_type;

   // One character waiting to be sent; drain holds it back until every
   // response still owed has arrived.
   typedef struct {
      logic [rdsc_pkg::CharWidth-1:0] ch;
      bit                             drain;
   } char_request_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_EVERY_FOURTH,
      READY_RARE
   } ready_pattern_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] char_code
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [31:0] value, [34:32] status, [40:35] depth

   char_request_type  pending_chars[$];
   calc_result_type   expected_results[$];
   calc_state_type    held_stack;       // follows the requests the block has taken
   calc_state_type    plan_stack;       // follows the stimulus as it is built
   bit                drain_next       = 1'b0;
   int                mismatch_count   = 0;
   int                responses_seen   = 0;
   int                idle_cycles      = 0;

   // Sender burst shaping
   int                burst_left       = 1;
   int                gap_left         = 0;

   // Receiver stall shaping
   int                phase_left       = 0;
   ready_pattern_type ready_pattern    = READY_ALWAYS;
   int                hold_off_left    = 0;
   bit                hold_off_done    = 1'b0;

   rpn_digit_stack_calculator #(
      .STACK_DEPTH(StackDepth)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one character to a calculator state and return the response it
   // must produce. Operands: b is the top entry, a the one below; a op b.
   function automatic calc_result_type rpn_eval_char(
         inout calc_state_type st, input logic [rdsc_pkg::CharWidth-1:0] ch);
      calc_result_type                 r;
      logic [rdsc_pkg::ValueWidth-1:0] a, b, mag_a, mag_b, quot;
      r = '0;
      r.status = rdsc_pkg::ST_PUSHED;
      if (ch >= rdsc_pkg::CHAR_ZERO && ch <= rdsc_pkg::CHAR_NINE) begin
         if (st.count >= StackDepth) begin
            r.status = rdsc_pkg::ST_OVERFLOW;
         end else begin
            r.value = 32'(ch - rdsc_pkg::CHAR_ZERO);
            st.entries[st.count] = r.value;
            st.count++;
         end
      end else if (ch inside {rdsc_pkg::CHAR_PLUS, rdsc_pkg::CHAR_MINUS,
                              rdsc_pkg::CHAR_STAR, rdsc_pkg::CHAR_SLASH}) begin
         if (st.count < 2) begin
            r.status = rdsc_pkg::ST_UNDERFLOW;
         end else begin
            b = st.entries[st.count-1];
            a = st.entries[st.count-2];
            st.count -= 2;
            if (ch == rdsc_pkg::CHAR_PLUS) begin
               r.value = a + b;
            end else if (ch == rdsc_pkg::CHAR_MINUS) begin
               r.value = a - b;
            end else if (ch == rdsc_pkg::CHAR_STAR) begin
               r.value = a * b;
            end else if (b == '0) begin
               // zero divisor: both operands are gone, nothing is pushed
               r.status = rdsc_pkg::ST_DIV_ZERO;
            end else begin
               // divide magnitudes, then fix the sign; MIN / -1 wraps to MIN
               mag_a = a[rdsc_pkg::ValueWidth-1] ? -a : a;
               mag_b = b[rdsc_pkg::ValueWidth-1] ? -b : b;
               quot  = mag_a / mag_b;
               r.value = (a[rdsc_pkg::ValueWidth-1] ^ b[rdsc_pkg::ValueWidth-1]) ? -quot
                                                                                 : quot;
            end
            if (r.status == rdsc_pkg::ST_PUSHED) begin
               st.entries[st.count] = r.value;
               st.count++;
            end
         end
      end else if (ch == rdsc_pkg::CHAR_EQUAL) begin
         if (st.count != 1) begin
            r.status = rdsc_pkg::ST_NOT_ONE;
         end else begin
            r.value  = st.entries[0];
            r.status = rdsc_pkg::ST_RESULT;
         end
      end else begin
         r.status = rdsc_pkg::ST_UNSUPPORTED;
      end
      r.depth = st.count[rdsc_pkg::DepthWidth-1:0];
      return r;
   endfunction

   function automatic logic [rdsc_pkg::CharWidth-1:0] random_digit();
      return rdsc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [rdsc_pkg::CharWidth-1:0] random_operator();
      rdsc_pkg::op_type op;
      op = rdsc_pkg::op_type'($urandom_range(0, 3));
      case (op)
         rdsc_pkg::OP_ADD: return rdsc_pkg::CHAR_PLUS;
         rdsc_pkg::OP_SUB: return rdsc_pkg::CHAR_MINUS;
         rdsc_pkg::OP_MUL: return rdsc_pkg::CHAR_STAR;
         default:          return rdsc_pkg::CHAR_SLASH;
      endcase
   endfunction

   // Queue one character and advance the planning copy of the stack, so the
   // generator knows the depth it is working at.
   task automatic plan_char(input logic [rdsc_pkg::CharWidth-1:0] ch);
      void'(rpn_eval_char(plan_stack, ch));
      pending_chars.push_back('{ch, drain_next || $urandom_range(0, 149) == 0});
      drain_next = 1'b0;
   endtask

   // Fold the planned stack down to one entry and present it, if one is left.
   task automatic plan_close();
      while (plan_stack.count > 1) plan_char(random_operator());
      if (plan_stack.count == 1) plan_char(rdsc_pkg::CHAR_EQUAL);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("[%0t] response %0d: %s got %0h, expected %0h",
               $time, responses_seen, what, got, want);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int kind;
      int item_goal;
      held_stack.entries = '0;
      held_stack.count   = 0;
      plan_stack         = held_stack;

      // Directed: errors on an empty stack, both ends of the character range,
      // every operator, truncating division of a negative value, zero divisor.
      plan_char(rdsc_pkg::CHAR_EQUAL);   plan_char(rdsc_pkg::CHAR_PLUS);
      plan_char(8'h00);                  plan_char(8'hff);
      plan_char(rdsc_pkg::CHAR_ZERO);    plan_char(rdsc_pkg::CHAR_EQUAL);
      plan_char(rdsc_pkg::CHAR_MINUS);   // only one entry held
      plan_char(rdsc_pkg::CHAR_NINE);    plan_char(rdsc_pkg::CHAR_MINUS);   // 0 - 9
      plan_char(rdsc_pkg::CHAR_ZERO + 8'd4);
      plan_char(rdsc_pkg::CHAR_SLASH);   // -9 / 4 = -2
      plan_char(rdsc_pkg::CHAR_ZERO + 8'd7); plan_char(rdsc_pkg::CHAR_STAR);
      plan_char(rdsc_pkg::CHAR_ZERO + 8'd3); plan_char(rdsc_pkg::CHAR_PLUS);
      plan_char(rdsc_pkg::CHAR_ZERO);    plan_char(rdsc_pkg::CHAR_SLASH);   // empties it
      plan_char(rdsc_pkg::CHAR_NINE);    plan_char(rdsc_pkg::CHAR_NINE);
      plan_char(rdsc_pkg::CHAR_STAR);    plan_char(rdsc_pkg::CHAR_EQUAL);

      // Pause the sender here until the directed part has fully drained.
      drain_next = 1'b1;
      item_goal  = pending_chars.size() + RandomItems;
      while (pending_chars.size() < item_goal) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            // well-formed expression with random digits and operators
            repeat ($urandom_range(3, 40)) begin
               if (plan_stack.count < 2 ||
                   (plan_stack.count < StackDepth && $urandom_range(0, 1) == 0))
                  plan_char(random_digit());
               else
                  plan_char(random_operator());
            end
            plan_close();
         end else if (kind < 65) begin
            // fill the stack, push past the top, then fold it back down
            while (plan_stack.count < StackDepth) plan_char(random_digit());
            repeat ($urandom_range(1, 3)) plan_char(random_digit());
            plan_close();
         end else if (kind < 72 && plan_stack.count + 3 <= StackDepth) begin
            // build 8^10 * 2, which wraps to the most negative value (or 8 * 2^10 for
            // the upper part of this range of kind), and divide it by -1
            plan_char(rdsc_pkg::CHAR_ZERO + 8'd8);
            repeat (9) begin
               plan_char(kind < 68 ? rdsc_pkg::CHAR_ZERO + 8'd8
                                   : rdsc_pkg::CHAR_ZERO + 8'd2);
               plan_char(rdsc_pkg::CHAR_STAR);
               kind = (kind < 68) ? kind : 68;
            end
            plan_char(rdsc_pkg::CHAR_ZERO + 8'd2);  plan_char(rdsc_pkg::CHAR_STAR);
            plan_char(rdsc_pkg::CHAR_ZERO);         plan_char(rdsc_pkg::CHAR_ZERO + 8'd1);
            plan_char(rdsc_pkg::CHAR_MINUS);        plan_char(rdsc_pkg::CHAR_SLASH);
            plan_close();
         end else begin
            // noise: any byte, stray operators and '=' at whatever depth
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 3))
                  0:       plan_char(rdsc_pkg::CHAR_EQUAL);
                  1:       plan_char(random_operator());
                  default: plan_char(8'($urandom_range(0, 255)));
               endcase
            end
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait for every character to go in and every response to come back,
      // then leave room for anything unexpected to show up.
      while (pending_chars.size() > 0 || expected_results.size() > 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("** rpn_digit_stack_calculator: PASSED **");
      end else begin
         $display("** rpn_digit_stack_calculator: FAILED **");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver: present queued characters in bursts; predict on acceptance
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // Take the accepted request into the predicted stack.
         if (req_tvalid && req_tready) begin
            expected_results.push_back(rpn_eval_char(held_stack, req_tdata));
            pending_chars.delete(0);
         end
         // Hold a request that is still waiting; otherwise pick the next move.
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_chars.size() > 0 &&
                         !(pending_chars[0].drain && expected_results.size() > 0)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_chars[0].ch;
               burst_left--;
               if (burst_left == 0) begin
                  // long bursts now and then give stretches with no idling
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(1, 12);
                  gap_left   = $urandom_range(1, 50);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall on a changing pattern, and once hold off for a long
   // stretch so the block backs up into its request side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_off_done && responses_seen >= 400) begin
         hold_off_done = 1'b1;
         hold_off_left = HoldOffCycles;
         rsp_tready <= 1'b0;
      end else begin
         if (phase_left == 0) begin
            phase_left    = $urandom_range(10, 200);
            ready_pattern = ready_pattern_type'($urandom_range(0, 3));
         end
         phase_left--;
         case (ready_pattern)
            READY_ALWAYS:       rsp_tready <= 1'b1;
            READY_COIN:         rsp_tready <= 1'($urandom_range(0, 1));
            READY_EVERY_FOURTH: rsp_tready <= (phase_left % 4 == 0);
            default:            rsp_tready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: compare each accepted response with the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      calc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("response with nothing owed, value", rsp_tdata[31:0], '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[31:0] !== want.value)
               report_mismatch("value", rsp_tdata[31:0], want.value);
            if (rsp_tdata[34:32] !== want.status)
               report_mismatch("status", 32'(rsp_tdata[34:32]), 32'(want.status));
            if (rsp_tdata[40:35] !== want.depth)
               report_mismatch("depth", 32'(rsp_tdata[40:35]), 32'(want.depth));
            if (rsp_tdata[47:41] !== '0)
               report_mismatch("padding", 32'(rsp_tdata[47:41]), '0);
         end
         responses_seen++;
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run when nothing moves on either side for too long
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("[%0t] no handshake for %0d cycles", $time, idle_cycles);
         $display("** rpn_digit_stack_calculator: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// File: sim.f
sv/rdsc_pkg.sv
sv/rpn_digit_stack_calculator.sv
tb/sv/rpn_digit_stack_calculator_test.sv
